@@ rtl/rigid_transform_voxel_weights_top_defines.svh @@
// Assertion macros used by the port-level checker of the voxel weights block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef RIGID_TRANSFORM_VOXEL_WEIGHTS_TOP_DEFINES_SVH
`define RIGID_TRANSFORM_VOXEL_WEIGHTS_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RTVW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTVW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rtvw_pkg.sv @@
// Package of the rigid transform voxel weights block: request types, register codes,
// fixed-point widths and constants. Depends on nothing.
`timescale 1ns / 1ps

package rtvw_pkg;

  // Fixed-point formats.
  localparam int unsigned COORD_W    = 20;  // Q12.8 point coordinate
  localparam int unsigned COEF_W     = 18;  // Q2.16 rotation coefficient
  localparam int unsigned TRANS_W    = 20;  // Q12.8 translation
  localparam int unsigned SCALE_W    = 16;  // Q4.12 inverse voxel size
  localparam int unsigned PROD_W     = COORD_W + COEF_W;
  localparam int unsigned ACC_W      = PROD_W + 2;
  localparam int unsigned V_W        = ACC_W + SCALE_W + 1;
  localparam int unsigned ACC_FRAC   = 36;
  localparam int unsigned IDX_W      = V_W - ACC_FRAC;
  localparam int unsigned VOX_W      = 16;
  localparam int unsigned WEIGHT_FRAC_BITS = 16;
  localparam int unsigned W_W        = WEIGHT_FRAC_BITS + 1;
  localparam int unsigned TMP_W      = 2 * W_W;

  localparam int unsigned ROT_W      = 3 * COEF_W;
  localparam int unsigned TRANS_ALL_W = 3 * TRANS_W;
  localparam int unsigned SCALE_ALL_W = 3 * SCALE_W;
  localparam int unsigned CFG_DATA_W = TRANS_ALL_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned NUM_STAGES = 6;

  // One half at the voxel index scale, used for round-half-up in nearest mode.
  localparam logic [V_W-1:0] HALF_VOXEL = V_W'(1) << (ACC_FRAC - 1);
  // One half at the weight scale, used when a weight product is rounded.
  localparam logic [TMP_W-1:0] ROUND_HALF = TMP_W'(1) << (WEIGHT_FRAC_BITS - 1);
  // The weight value 1.0.
  localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(1) << WEIGHT_FRAC_BITS;

  localparam logic signed [IDX_W-1:0] IDX_MAX = IDX_W'((1 << (VOX_W - 1)) - 1);
  localparam logic signed [IDX_W-1:0] IDX_MIN = -IDX_W'(1 << (VOX_W - 1));
  localparam logic signed [VOX_W-1:0] VOX_MAX = IDX_MAX[VOX_W-1:0];
  localparam logic signed [VOX_W-1:0] VOX_MIN = IDX_MIN[VOX_W-1:0];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW_X   = 3'd0,
    REG_ROT_ROW_Y   = 3'd1,
    REG_ROT_ROW_Z   = 3'd2,
    REG_TRANSLATION = 3'd3,
    REG_INV_SCALE   = 3'd4,
    REG_INTERP_MODE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [COORD_W-1:0] z_in;
  } in_req_t;

  typedef struct packed {
    logic signed [VOX_W-1:0] vox_x;
    logic signed [VOX_W-1:0] vox_y;
    logic signed [VOX_W-1:0] vox_z;
    logic [W_W-1:0] w000;
    logic [W_W-1:0] w001;
    logic [W_W-1:0] w010;
    logic [W_W-1:0] w011;
    logic [W_W-1:0] w100;
    logic [W_W-1:0] w101;
    logic [W_W-1:0] w110;
    logic [W_W-1:0] w111;
  } out_req_t;

endpackage

@@ rtl/rigid_transform_voxel_weights_top.sv @@
// Top level of the rigid transform voxel weights block: six-stage pipeline from a
// Q12.8 point to voxel indices and trilinear corner weights. Depends on rtvw_pkg.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    in_req_i  (rtvw_pkg::in_req_t)
//   out      output     out_valid_o / out_stall_i  out_req_o (rtvw_pkg::out_req_t)
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One request is accepted per cycle while the input is not stalled; its result passes
// through the six register stages (products, sum, scale, split, two weight
// multiplies).
// Reset clears the configuration registers and stage valid bits, not the payload.
// A stalled output holds its request; a stage loads when it is empty or its successor
// loads, so bubbles close up and the input stalls only once all six stages are full.
`timescale 1ns / 1ps

module rigid_transform_voxel_weights_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  rtvw_pkg::in_req_t                     in_req_i,
  output logic                                  in_stall_o,
  output logic                                  out_valid_o,
  output rtvw_pkg::out_req_t                    out_req_o,
  input  logic                                  out_stall_i,
  input  logic                                  cfg_we_i,
  input  logic [rtvw_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rtvw_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must change them only while the pipeline
  // is empty, as every stage reads them directly; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [rtvw_pkg::ROT_W-1:0]       rot_q [3];
  logic [rtvw_pkg::TRANS_ALL_W-1:0] trans_q;
  logic [rtvw_pkg::SCALE_ALL_W-1:0] scale_q;
  logic                             mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= '0;
      rot_q[1] <= '0;
      rot_q[2] <= '0;
      trans_q  <= '0;
      scale_q  <= '0;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (rtvw_pkg::cfg_reg_e'(cfg_idx_i))
        rtvw_pkg::REG_ROT_ROW_X:   rot_q[0] <= cfg_wdata_i[rtvw_pkg::ROT_W-1:0];
        rtvw_pkg::REG_ROT_ROW_Y:   rot_q[1] <= cfg_wdata_i[rtvw_pkg::ROT_W-1:0];
        rtvw_pkg::REG_ROT_ROW_Z:   rot_q[2] <= cfg_wdata_i[rtvw_pkg::ROT_W-1:0];
        rtvw_pkg::REG_TRANSLATION: trans_q  <= cfg_wdata_i[rtvw_pkg::TRANS_ALL_W-1:0];
        rtvw_pkg::REG_INV_SCALE:   scale_q  <= cfg_wdata_i[rtvw_pkg::SCALE_ALL_W-1:0];
        rtvw_pkg::REG_INTERP_MODE: mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or its content moves on.
  // ---------------------------------------------------------------------------
  logic [rtvw_pkg::NUM_STAGES-1:0] valid_q;
  logic [rtvw_pkg::NUM_STAGES-1:0] load;

  always_comb begin
    load[rtvw_pkg::NUM_STAGES-1] = !valid_q[rtvw_pkg::NUM_STAGES-1] || !out_stall_i;
    for (int s = rtvw_pkg::NUM_STAGES - 2; s >= 0; s--) begin
      load[s] = !valid_q[s] || load[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int s = 1; s < rtvw_pkg::NUM_STAGES; s++) begin
        if (load[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  assign in_stall_o  = !load[0];
  assign out_valid_o = valid_q[rtvw_pkg::NUM_STAGES-1];

  // ---------------------------------------------------------------------------
  // Stage 1: the nine rotation products, one 20x18 multiplier each.
  // ---------------------------------------------------------------------------
  logic signed [rtvw_pkg::COORD_W-1:0] pt [3];
  logic signed [rtvw_pkg::PROD_W-1:0]  prod_d [3][3];
  logic signed [rtvw_pkg::PROD_W-1:0]  prod_q [3][3];

  assign pt[0] = in_req_i.x_in;
  assign pt[1] = in_req_i.y_in;
  assign pt[2] = in_req_i.z_in;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        prod_d[a][i] = $signed(rot_q[a][i*rtvw_pkg::COEF_W +: rtvw_pkg::COEF_W]) * pt[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      prod_q <= prod_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sum of the products plus the translation, aligned to Q.24.
  // ---------------------------------------------------------------------------
  logic signed [rtvw_pkg::ACC_W-1:0] acc_d [3];
  logic signed [rtvw_pkg::ACC_W-1:0] acc_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc_d[a] = rtvw_pkg::ACC_W'(prod_q[a][0]) + rtvw_pkg::ACC_W'(prod_q[a][1])
               + rtvw_pkg::ACC_W'(prod_q[a][2])
               + rtvw_pkg::ACC_W'($signed({trans_q[a*rtvw_pkg::TRANS_W +: rtvw_pkg::TRANS_W],
                                           16'b0}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      acc_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: multiply by the unsigned inverse voxel size; 36 fraction bits.
  // ---------------------------------------------------------------------------
  logic signed [rtvw_pkg::V_W-1:0] val_d [3];
  logic signed [rtvw_pkg::V_W-1:0] val_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      val_d[a] = acc_q[a]
               * $signed({1'b0, scale_q[a*rtvw_pkg::SCALE_W +: rtvw_pkg::SCALE_W]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      val_q <= val_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round or floor to a voxel index, saturate, and take the fraction
  // and its complement. A clamped axis gets a zero fraction.
  // ---------------------------------------------------------------------------
  logic signed [rtvw_pkg::V_W-1:0]   split_val [3];
  logic signed [rtvw_pkg::IDX_W-1:0] split_idx [3];
  logic [rtvw_pkg::WEIGHT_FRAC_BITS-1:0] split_frac [3];
  logic signed [rtvw_pkg::VOX_W-1:0] vox_d [3];
  logic signed [rtvw_pkg::VOX_W-1:0] vox4_q [3];
  logic [rtvw_pkg::W_W-1:0]          frac_d [3][2];
  logic [rtvw_pkg::W_W-1:0]          frac_q [3][2];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      split_val[a] = mode_q ? val_q[a] : val_q[a] + $signed(rtvw_pkg::HALF_VOXEL);
      split_idx[a] = split_val[a][rtvw_pkg::V_W-1:rtvw_pkg::ACC_FRAC];
      split_frac[a] = split_val[a][rtvw_pkg::ACC_FRAC-1 -: rtvw_pkg::WEIGHT_FRAC_BITS];
      if (split_idx[a] > rtvw_pkg::IDX_MAX) begin
        vox_d[a] = rtvw_pkg::VOX_MAX;
        split_frac[a] = '0;
      end else if (split_idx[a] < rtvw_pkg::IDX_MIN) begin
        vox_d[a] = rtvw_pkg::VOX_MIN;
        split_frac[a] = '0;
      end else begin
        vox_d[a] = split_idx[a][rtvw_pkg::VOX_W-1:0];
      end
      frac_d[a][1] = {1'b0, split_frac[a]};
      frac_d[a][0] = rtvw_pkg::WEIGHT_ONE - {1'b0, split_frac[a]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      vox4_q <= vox_d;
      frac_q <= frac_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: the four rounded x-by-y partial weights.
  // ---------------------------------------------------------------------------
  logic [rtvw_pkg::TMP_W-1:0]        pxy_prod [4];
  logic [rtvw_pkg::W_W-1:0]          pxy_d [4];
  logic [rtvw_pkg::W_W-1:0]          pxy_q [4];
  logic [rtvw_pkg::W_W-1:0]          fz5_q [2];
  logic signed [rtvw_pkg::VOX_W-1:0] vox5_q [3];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      pxy_prod[j] = frac_q[0][j/2] * frac_q[1][j%2] + rtvw_pkg::ROUND_HALF;
      pxy_d[j]    = pxy_prod[j][rtvw_pkg::WEIGHT_FRAC_BITS +: rtvw_pkg::W_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      pxy_q  <= pxy_d;
      fz5_q  <= frac_q[2];
      vox5_q <= vox4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: the eight corner weights, forced to zero in nearest mode. This is
  // the output register.
  // ---------------------------------------------------------------------------
  logic [rtvw_pkg::TMP_W-1:0]        w_prod [8];
  logic [rtvw_pkg::W_W-1:0]          w_d [8];
  logic [rtvw_pkg::W_W-1:0]          w_q [8];
  logic signed [rtvw_pkg::VOX_W-1:0] vox6_q [3];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      w_prod[k] = pxy_q[k/2] * fz5_q[k%2] + rtvw_pkg::ROUND_HALF;
      w_d[k]    = mode_q ? w_prod[k][rtvw_pkg::WEIGHT_FRAC_BITS +: rtvw_pkg::W_W] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      w_q    <= w_d;
      vox6_q <= vox5_q;
    end
  end

  assign out_req_o.vox_x = vox6_q[0];
  assign out_req_o.vox_y = vox6_q[1];
  assign out_req_o.vox_z = vox6_q[2];
  assign out_req_o.w000  = w_q[0];
  assign out_req_o.w001  = w_q[1];
  assign out_req_o.w010  = w_q[2];
  assign out_req_o.w011  = w_q[3];
  assign out_req_o.w100  = w_q[4];
  assign out_req_o.w101  = w_q[5];
  assign out_req_o.w110  = w_q[6];
  assign out_req_o.w111  = w_q[7];

endmodule

@@ rtl/rtvw_checker.sv @@
// Port-level checker for the rigid transform voxel weights block, bound to its top.
// Depends on rtvw_pkg and rigid_transform_voxel_weights_top_defines.svh.
`timescale 1ns / 1ps
`include "rigid_transform_voxel_weights_top_defines.svh"

module rtvw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input rtvw_pkg::out_req_t out_req_o,
  input logic               out_stall_i
);

  // A stalled result stays offered.
  `RTVW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // A stalled result does not change.
  `RTVW_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_req_o), "stalled result changed")

  // The input side only stalls when the output is full and held.
  `RTVW_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without back pressure")

  // Draining the output frees the whole pipeline for a new request.
  `RTVW_ASSERT_NOW(a_drain_frees, out_valid_o && !out_stall_i, !in_stall_o, "input stalled while output drains")

endmodule

bind rigid_transform_voxel_weights_top rtvw_checker u_rtvw_checker (.*);
